/* rtl/core/hsla_pkg.sv */
// ----------------------------------------------------------------------------
// HSLA to RGBA converter package
// Shared widths, defaults and the hue segment code of the color converter.
// ----------------------------------------------------------------------------
package hsla_pkg;

  // Default number of fraction bits of the input fractions (1.0 = 2**FRAC_BITS)
  localparam int FRAC_BITS_DEF = 16;

  // Width of one output color channel
  localparam int CHAN_W = 8;

  // Piece of the hue curve that a channel hue falls in
  typedef enum logic [1:0] {
    SEG_RISE,   // first sixth: inner rising toward outer
    SEG_HIGH,   // up to one half: outer value
    SEG_FALL,   // up to two thirds: outer falling toward inner
    SEG_LOW     // rest of the turn: inner value
  } seg_t;

endpackage

/* rtl/core/hsla_in_if.sv */
// ----------------------------------------------------------------------------
// HSLA request channel
// Valid/ready channel carrying one HSLA color as unsigned fractions.
// ----------------------------------------------------------------------------
interface hsla_in_if
  import hsla_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);

  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   lightness;
  logic [FRAC_BITS:0]   alpha_in;

  modport source (
    output valid, hue, saturation, lightness, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, hue, saturation, lightness, alpha_in,
    output ready
  );

endinterface

/* rtl/core/hsla_out_if.sv */
// ----------------------------------------------------------------------------
// RGBA result channel
// Valid/ready channel carrying one 8-bit RGBA color.
// ----------------------------------------------------------------------------
interface hsla_out_if
  import hsla_pkg::*;
;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha_out;

  modport source (
    output valid, red, green, blue, alpha_out,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, alpha_out,
    output ready
  );

endinterface

/* rtl/core/hsla_to_rgba_converter.sv */
// ----------------------------------------------------------------------------
// HSLA to RGBA converter
// Five-stage pipeline turning fixed-point HSLA fractions into 8-bit RGBA.
// ----------------------------------------------------------------------------
//
//  channel | role | fields                                   | width
//  --------+------+------------------------------------------+----------------
//  hsla    | sink | hue, saturation, lightness, alpha_in     | FRAC_BITS+1 each
//  rgba    | src  | red, green, blue, alpha_out              | 8 each
//
//  An accepted request passes five registered stages to its result on rgba;
//  one request per cycle is sustained while rgba.ready holds. The depth is
//  set by the l*s multiplier (stage 1), the outer/inner adders (stage 2), the
//  per-channel diff*slope multipliers (stage 3), the segment sum (stage 4) and
//  the scale by 255 with clamp (stage 5, the output register).
//  Each stage advances when it is empty or the next one advances, so bubbles
//  close up and a stalled rgba side still lets requests fill empty stages.
//  Reset clears only the stage valid bits; outside reset no request is lost or repeated.
//
module hsla_to_rgba_converter
  import hsla_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hsla_in_if.sink     hsla,
  hsla_out_if.source  rgba
);

  localparam int F  = FRAC_BITS;
  localparam int IW = F + 1;         // input fraction width
  localparam int VW = F + 4;         // outer, inner, diff (signed)
  localparam int MW = F + 4;         // hue multiples
  localparam int PW = 2 * F + 6;     // segment value with 2F fraction bits
  localparam int BW = PW + 8;        // segment value times 255
  localparam int AW = IW + 8;        // alpha times 255

  localparam logic signed [F+2:0] ONE_H   = (F + 3)'(1) << F;
  localparam logic signed [F+2:0] THIRD_H = ONE_H / 3;
  localparam logic [MW-1:0]       ONE_M   = MW'(1) << F;
  localparam logic [MW-1:0]       TWO_M   = MW'(2) << F;
  localparam logic [IW-1:0]       HALF_I  = IW'(1) << (F - 1);
  localparam logic [2*IW:0]       RND_C   = (2 * IW + 1)'((1 << F) - 1);

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or drains this cycle
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || rgba.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign hsla.ready = en1;
  assign rgba.valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= hsla.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: l*s product, lightness range, alpha byte
  // --------------------------------------------------------------------------
  logic [2*IW-1:0]   s1_ls;
  logic [IW-1:0]     s1_l;
  logic [IW-1:0]     s1_s;
  logic              s1_lo;
  logic [CHAN_W-1:0] s1_alpha;

  logic [AW-1:0]     alpha_x255;
  logic [8:0]        alpha_sh;
  logic [CHAN_W-1:0] alpha_byte;

  always_comb begin
    alpha_x255 = (AW'(hsla.alpha_in) << 8) - AW'(hsla.alpha_in);
    alpha_sh   = alpha_x255[F+8:F];
    // saturate alphas at or above one
    alpha_byte = alpha_sh[8] ? {CHAN_W{1'b1}} : alpha_sh[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ls    <= (2 * IW)'(hsla.lightness) * (2 * IW)'(hsla.saturation);
      s1_l     <= hsla.lightness;
      s1_s     <= hsla.saturation;
      s1_lo    <= hsla.lightness < HALF_I;
      s1_alpha <= alpha_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: outer value, inner value and their difference
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] s2_outer;
  logic signed [VW-1:0] s2_inner;
  logic signed [VW-1:0] s2_diff;
  logic [CHAN_W-1:0]    s2_alpha;

  logic [F+1:0]         ls_floor;
  logic [2*IW:0]        ls_rnd;
  logic [F+2:0]         ls_ceil;
  logic signed [VW-1:0] outer_c;
  logic signed [VW-1:0] inner_c;

  always_comb begin
    ls_floor = s1_ls[2*IW-1:F];
    ls_rnd   = {1'b0, s1_ls} + RND_C;
    ls_ceil  = ls_rnd[2*IW:F];
    // below one half: l*(1+s), rounded down; else l+s-l*s with l*s rounded up
    if (s1_lo) begin
      outer_c = $signed(VW'(s1_l) + VW'(ls_floor));
    end else begin
      outer_c = $signed(VW'(s1_l) + VW'(s1_s) - VW'(ls_ceil));
    end
    inner_c = $signed(VW'(s1_l) << 1) - outer_c;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_outer <= outer_c;
      s2_inner <= inner_c;
      s2_diff  <= outer_c - inner_c;
      s2_alpha <= s1_alpha;
    end
  end

  // Alpha rides along to the output register
  logic [CHAN_W-1:0] s3_alpha, s4_alpha, s5_alpha;

  always_ff @(posedge clk) begin
    if (en3) s3_alpha <= s2_alpha;
    if (en4) s4_alpha <= s3_alpha;
    if (en5) s5_alpha <= s4_alpha;
  end

  // --------------------------------------------------------------------------
  // Color lanes: red (hue + 1/3), green (hue), blue (hue - 1/3)
  // --------------------------------------------------------------------------
  logic [CHAN_W-1:0] chan [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    localparam logic signed [F+2:0] OFS = (c == 0) ? THIRD_H :
                                          (c == 1) ? '0 : -THIRD_H;

    logic signed [F+2:0] hx;
    logic signed [F+2:0] hw;
    logic [MW-1:0]       hv;
    logic [MW-1:0]       hv2;
    logic [MW-1:0]       hv3;
    logic [MW-1:0]       hv6;
    logic [MW-1:0]       fall;
    seg_t                seg_c;
    logic [F:0]          slope_c;

    seg_t                s1_seg, s2_seg;
    logic [F:0]          s1_slope, s2_slope;
    logic signed [PW-1:0] s3_prod;
    logic signed [VW-1:0] s3_base;
    logic                s3_use;
    logic signed [PW-1:0] s4_val;
    logic [BW-1:0]       val_u;
    logic [BW-1:0]       val_x255;
    logic [BW-2*F-1:0]   val_sh;
    logic [CHAN_W-1:0]   byte_c;
    logic [CHAN_W-1:0]   s5_byte;

    // Stage 1: wrap the channel hue once and pick its segment and slope
    always_comb begin
      hx = $signed({2'b00, hsla.hue}) + OFS;
      if (hx < 0) begin
        hw = hx + ONE_H;
      end else if (hx > ONE_H) begin
        hw = hx - ONE_H;
      end else begin
        hw = hx;
      end
      hv   = MW'(hw[F:0]);
      hv2  = hv << 1;
      hv3  = hv2 + hv;
      hv6  = hv3 << 1;
      fall = (TWO_M - hv3) << 1;
      if (hv6 < ONE_M) begin
        seg_c   = SEG_RISE;
        slope_c = hv6[F:0];
      end else if (hv2 < ONE_M) begin
        seg_c   = SEG_HIGH;
        slope_c = '0;
      end else if (hv3 < TWO_M) begin
        seg_c   = SEG_FALL;
        slope_c = fall[F:0];
      end else begin
        // includes hues still above one after the wrap
        seg_c   = SEG_LOW;
        slope_c = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en1) begin
        s1_seg   <= seg_c;
        s1_slope <= slope_c;
      end
      if (en2) begin
        s2_seg   <= s1_seg;
        s2_slope <= s1_slope;
      end
    end

    // Stage 3: diff * slope, pick the base value
    always_ff @(posedge clk) begin
      if (en3) begin
        s3_prod <= PW'(s2_diff) * PW'($signed({1'b0, s2_slope}));
        s3_base <= (s2_seg == SEG_HIGH) ? s2_outer : s2_inner;
        s3_use  <= (s2_seg == SEG_RISE) || (s2_seg == SEG_FALL);
      end
    end

    // Stage 4: channel value with 2F fraction bits
    always_ff @(posedge clk) begin
      if (en4) begin
        s4_val <= (PW'(s3_base) <<< F) + (s3_use ? s3_prod : '0);
      end
    end

    // Stage 5: scale by 255, drop 2F fraction bits, clamp to a byte
    always_comb begin
      val_u    = BW'($unsigned(s4_val));
      val_x255 = (val_u << 8) - val_u;
      val_sh   = val_x255[BW-1:2*F];
      if (s4_val <= 0) begin
        byte_c = '0;
      end else if (|val_sh[BW-2*F-1:CHAN_W]) begin
        byte_c = {CHAN_W{1'b1}};
      end else begin
        byte_c = val_sh[CHAN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en5) s5_byte <= byte_c;
    end

    assign chan[c] = s5_byte;
  end

  assign rgba.red       = chan[0];
  assign rgba.green     = chan[1];
  assign rgba.blue      = chan[2];
  assign rgba.alpha_out = s5_alpha;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic       acc_in, acc_out;
  logic [4:0] vld;

  assign acc_in  = hsla.valid && hsla.ready;
  assign acc_out = rgba.valid && rgba.ready;
  assign vld     = {v5, v4, v3, v2, v1};

  // an accepted request always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    acc_in |=> v1)
    else $error("accepted request did not enter stage 1");

  // an empty first stage never blocks requests
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> hsla.ready)
    else $error("request blocked with stage 1 empty");

  // items in flight change only by accepted requests and taken results
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(vld) == $past($countones(vld))
                                 + int'($past(acc_in)) - int'($past(acc_out))))
    else $error("pipeline lost or duplicated an item");

  // a held stage 4 keeps its alpha value while the output is stalled
  a_hold_s4: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en4) |=> (v4 && $stable(s4_alpha)))
    else $error("stalled stage 4 changed");

endmodule
